### sv/dnsa_pkg.sv
package dnsa_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = 2;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_QTAIL  = 3'd2;
  localparam logic [2:0] PH_RECORD = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  localparam logic [3:0] RIDX_TYPE_HI = 4'd2;
  localparam logic [3:0] RIDX_TYPE_LO = 4'd3;
  localparam logic [3:0] RIDX_LEN_HI  = 4'd10;
  localparam logic [3:0] RIDX_LEN_LO  = 4'd11;
  localparam logic [3:0] ADDR_BYTES   = 4'd4;
  localparam logic [7:0] QTAIL_BYTES  = 8'd4;

  // work handed from the parser to the result stage
  typedef struct packed {
    logic       shift_en;  // data byte goes into the address register
    logic       rcode_en;  // data byte holds the response code
    logic       fin_en;    // an A record with a full address completes
    logic       last;      // final byte of the packet
    logic [7:0] data;
  } cmd_t;

endpackage

### sv/dns_a_record_extractor.sv
// Bytes that need a result step are pushed into the queue as commands; the result registers pop them.
// Throughput: one byte per cycle while the queue is not full; the parser classifies each byte
// combinationally and a 4-entry queue feeds the result register, one entry per cycle unless stalled.
// Results appear only for completed A records and for the final byte of a packet.
// Reset (rst_n low, synchronous) clears parser state, queue pointers and result valid.
module dns_a_record_extractor #(
  parameter int unsigned MAX_RECORDS = 16,
  parameter int unsigned MAX_PACKET  = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_has_address,
  output logic [31:0] out_address,
  output logic        out_done_res,
  output logic        out_ok,
  output logic [4:0]  out_record_count
);

  logic           acc;
  logic           f_valid;
  dnsa_pkg::cmd_t f_cmd;
  logic           q_not_full;
  logic           q_not_empty;
  logic           q_pop;
  dnsa_pkg::cmd_t q_cmd;

  assign in_ready = q_not_full;
  assign acc      = in_valid && in_ready;

  dnsa_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .data_byte(in_data_byte),
    .last_byte(in_last_byte),
    .cmd_valid(f_valid),
    .cmd      (f_cmd)
  );

  dnsa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_cmd (f_cmd),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_cmd  (q_cmd)
  );

  dnsa_back #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_not_empty),
    .cmd             (q_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_has_address (out_has_address),
    .out_address     (out_address),
    .out_done_res    (out_done_res),
    .out_ok          (out_ok),
    .out_record_count(out_record_count)
  );

endmodule

### sv/dnsa_front.sv
module dnsa_front #(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              cmd_valid,
  output dnsa_pkg::cmd_t    cmd
);

  localparam int unsigned PW = $clog2(MAX_PACKET + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    skip_r, skip_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic          type_hz_r, type_hz_nxt;
  logic          type_a_r, type_a_nxt;
  logic [15:0]   drem_r, drem_nxt;
  logic [15:0]   drem_dec;
  logic [15:0]   len_full;
  logic [3:0]    idx_inc;
  logic          in_range;

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    idx_nxt     = idx_r;
    type_hz_nxt = type_hz_r;
    type_a_nxt  = type_a_r;
    drem_nxt    = drem_r;
    cmd         = '0;
    cmd.data    = data_byte;
    cmd.last    = last_byte;
    in_range    = pos_r < PW'(MAX_PACKET);
    drem_dec    = drem_r - 16'd1;
    len_full    = {drem_r[15:8], data_byte};
    idx_inc     = idx_r + 4'd1;
    if (in_range) begin
      unique case (phase_r)
        dnsa_pkg::PH_HEADER: begin
          if (pos_r == PW'(3)) cmd.rcode_en = 1'b1;
          if (pos_r == PW'(11)) begin
            phase_nxt = dnsa_pkg::PH_NAME;
            skip_nxt  = 8'd0;
          end
        end
        dnsa_pkg::PH_NAME: begin
          if (skip_r != 8'd0) begin
            skip_nxt = skip_r - 8'd1;
          end else if (data_byte == 8'd0) begin
            phase_nxt = dnsa_pkg::PH_QTAIL;
            skip_nxt  = dnsa_pkg::QTAIL_BYTES;
          end else begin
            skip_nxt = data_byte;
          end
        end
        dnsa_pkg::PH_QTAIL: begin
          if (skip_r != 8'd0) skip_nxt = skip_r - 8'd1;
          if (skip_nxt == 8'd0) begin
            phase_nxt = dnsa_pkg::PH_RECORD;
            idx_nxt   = 4'd0;
          end
        end
        dnsa_pkg::PH_RECORD: begin
          if (idx_r == dnsa_pkg::RIDX_TYPE_HI) type_hz_nxt = (data_byte == 8'd0);
          else if (idx_r == dnsa_pkg::RIDX_TYPE_LO)
            type_a_nxt = type_hz_r && (data_byte == 8'd1);
          else if (idx_r == dnsa_pkg::RIDX_LEN_HI) drem_nxt = {data_byte, 8'd0};
          else if (idx_r == dnsa_pkg::RIDX_LEN_LO) drem_nxt = len_full;
          if (idx_r >= dnsa_pkg::RIDX_LEN_LO) begin
            idx_nxt = 4'd0;
            // zero-length data: record ends here with nothing to report
            if (len_full != 16'd0) phase_nxt = dnsa_pkg::PH_DATA;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        dnsa_pkg::PH_DATA: begin
          if (idx_r < dnsa_pkg::ADDR_BYTES) begin
            cmd.shift_en = 1'b1;
            idx_nxt      = idx_inc;
          end
          drem_nxt = drem_dec;
          if (drem_dec == 16'd0) begin
            cmd.fin_en = type_a_r && (idx_nxt >= dnsa_pkg::ADDR_BYTES);
            phase_nxt  = dnsa_pkg::PH_RECORD;
            idx_nxt    = 4'd0;
          end
        end
        default: begin
          phase_nxt = dnsa_pkg::PH_HEADER;
        end
      endcase
      pos_nxt = pos_r + PW'(1);
    end
    cmd_valid = acc && (cmd.shift_en || cmd.rcode_en || cmd.fin_en || cmd.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_byte)) begin
      pos_r     <= '0;
      phase_r   <= dnsa_pkg::PH_HEADER;
      skip_r    <= 8'd0;
      idx_r     <= 4'd0;
      type_hz_r <= 1'b0;
      type_a_r  <= 1'b0;
      drem_r    <= 16'd0;
    end else if (acc) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      idx_r     <= idx_nxt;
      type_hz_r <= type_hz_nxt;
      type_a_r  <= type_a_nxt;
      drem_r    <= drem_nxt;
    end
  end

`ifndef SYNTH
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dnsa_pkg::PH_DATA |-> drem_r != 16'd0)
    else $error("data phase with no data bytes left");
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_PACKET))
    else $error("byte position past packet limit");
`endif

endmodule

### sv/dnsa_queue.sv
module dnsa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dnsa_pkg::cmd_t push_cmd,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output dnsa_pkg::cmd_t pop_cmd
);

  dnsa_pkg::cmd_t              mem_r [dnsa_pkg::QDEPTH];
  logic [dnsa_pkg::QPTRW-1:0]  wptr_r, rptr_r;
  logic [dnsa_pkg::QPTRW:0]    cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign not_full  = cnt_r != (dnsa_pkg::QPTRW + 1)'(dnsa_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (dnsa_pkg::QPTRW + 1)'(dnsa_pkg::QDEPTH))
    else $error("queue count over depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

### sv/dnsa_back.sv
module dnsa_back #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  dnsa_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_has_address,
  output logic [31:0]    out_address,
  output logic           out_done_res,
  output logic           out_ok,
  output logic [4:0]     out_record_count
);

  localparam int unsigned FW = $clog2(MAX_RECORDS + 1);

  logic [31:0]   shift_r, shift_nxt;
  logic          err_r, err_nxt;
  logic [FW-1:0] found_r, found_nxt;
  logic          emit;
  logic          res_valid;
  logic          out_valid_r;
  logic          has_r;
  logic [31:0]   addr_r;
  logic          done_r;
  logic          ok_r;
  logic [FW-1:0] cnt_r;
  logic [FW+4:0] cnt_ext;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  always_comb begin
    shift_nxt = cmd.shift_en ? {shift_r[23:0], cmd.data} : shift_r;
    err_nxt   = cmd.rcode_en ? (cmd.data[3:0] != 4'd0) : err_r;
    emit      = cmd.fin_en && !err_nxt && (found_r < FW'(MAX_RECORDS));
    found_nxt = found_r + FW'(emit);
    res_valid = emit || cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= 1'b0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        err_r       <= cmd.last ? 1'b0 : err_nxt;
        found_r     <= cmd.last ? '0 : found_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      shift_r <= shift_nxt;
      has_r   <= emit;
      addr_r  <= emit ? shift_nxt : 32'd0;
      done_r  <= cmd.last;
      ok_r    <= cmd.last && !err_nxt;
      cnt_r   <= found_nxt;
    end
  end

  assign cnt_ext          = (FW + 5)'(cnt_r);
  assign out_valid        = out_valid_r;
  assign out_has_address  = has_r;
  assign out_address      = addr_r;
  assign out_done_res     = done_r;
  assign out_ok           = ok_r;
  assign out_record_count = cnt_ext[4:0];

`ifndef SYNTH
  a_res_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> has_r)
    else $error("result with neither address nor done");
  a_found_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && has_r && !done_r |-> found_r != '0)
    else $error("address emitted without record count");
`endif

endmodule
